/* hw/rtl/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and codes for the first-fit heap allocator
// Request kinds, status codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package ffha_pkg;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned ALIGN_W = 17;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_REALLOC = 2'd2,
    KIND_ALIGNED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_INVALID = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  localparam logic REG_HEAP_START = 1'b0;
  localparam logic REG_HEAP_CAP   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIND_RD,
    S_FIND_CMP,
    S_FIT_RD,
    S_FIT_CMP,
    S_APPEND,
    S_FINISH,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

/* hw/rtl/first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: block table bookkeeping for an upward heap
// One sequencer walks the block table through one registered read port.
// ----------------------------------------------------------------------------
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | kind, request_size, block_address, alignment
// out     | out | out_valid/out_ready | result_address, status, copy_length, raw_address
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
// Each table entry visited takes a read state and then a compare state;
// reallocate may walk the table twice (lookup, then first-fit search).
// in_ready is low from acceptance until the result item is taken.
// Reset (rst_n low, synchronous) empties the table; no clearing pass.
`default_nettype none
module first_fit_heap_allocator #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_kind,
  input  wire logic [31:0]                 in_request_size,
  input  wire logic [47:0]                 in_block_address,
  input  wire logic [16:0]                 in_alignment,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [47:0]                      out_result_address,
  output logic [1:0]                       out_status,
  output logic [31:0]                      out_copy_length,
  output logic [47:0]                      out_raw_address,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [0:0]                  cfg_index,
  input  wire logic [47:0]                 cfg_data
);
  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

  ffha_pkg::state_t st_r, st_nxt;

  logic [47:0] mem_addr [MAX_BLOCKS];
  logic [31:0] mem_size [MAX_BLOCKS];
  logic        mem_free [MAX_BLOCKS];
  logic [47:0] rd_addr_r;
  logic [31:0] rd_size_r;
  logic        rd_free_r;

  logic [47:0] heap_start_r;
  logic [31:0] heap_cap_r;
  logic [CW-1:0] count_r;
  logic [32:0] used_r;

  logic [1:0]  kind_r;
  logic [31:0] size_r;
  logic [47:0] baddr_r;
  logic [16:0] align_r;
  logic [CW-1:0] idx_r;
  logic [IW-1:0] old_idx_r;
  logic [31:0] old_size_r;
  logic        moving_r;
  logic [34:0] need_r;
  logic [47:0] res_r, raw_r;
  logic [1:0]  stat_r;
  logic [31:0] copy_r;

  logic [34:0] need_calc;
  logic [35:0] total;
  logic [47:0] aligned;
  logic [16:0] am1;

  assign in_ready  = (st_r == ffha_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (st_r == ffha_pkg::S_OUT);
  assign out_result_address = res_r;
  assign out_status = stat_r;
  assign out_copy_length = copy_r;
  assign out_raw_address = raw_r;

  assign am1 = align_r - 17'd1;
  always_comb begin
    if (kind_r == ffha_pkg::KIND_ALIGNED) begin
      need_calc = ({3'd0, size_r} + {18'd0, am1} + 35'd15) & ~35'd7;
    end else begin
      need_calc = ({3'd0, size_r} + 35'd7) & ~35'd7;
    end
  end
  assign total = {3'd0, used_r} + {1'b0, need_r} + 36'(HEADER_BYTES);
  assign aligned = (res_r + 48'd8 + {31'd0, am1}) & ~{31'd0, am1};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ffha_pkg::S_IDLE: if (in_valid) st_nxt = ffha_pkg::S_DECODE;
      ffha_pkg::S_DECODE: begin
        case (kind_r)
          ffha_pkg::KIND_ALLOC:
            st_nxt = (size_r == 32'd0) ? ffha_pkg::S_OUT : ffha_pkg::S_FIT_RD;
          ffha_pkg::KIND_FREE:
            st_nxt = (baddr_r == 48'd0) ? ffha_pkg::S_OUT : ffha_pkg::S_FIND_RD;
          ffha_pkg::KIND_REALLOC:
            st_nxt = (baddr_r == 48'd0) ?
                     ((size_r == 32'd0) ? ffha_pkg::S_OUT : ffha_pkg::S_FIT_RD) :
                     ffha_pkg::S_FIND_RD;
          default:
            st_nxt = (align_r < 17'd8 || (align_r & am1) != 17'd0 ||
                      size_r == 32'd0) ? ffha_pkg::S_OUT : ffha_pkg::S_FIT_RD;
        endcase
      end
      ffha_pkg::S_FIND_RD:
        st_nxt = (idx_r >= count_r) ? ffha_pkg::S_OUT : ffha_pkg::S_FIND_CMP;
      ffha_pkg::S_FIND_CMP: begin
        if (rd_addr_r != baddr_r) st_nxt = ffha_pkg::S_FIND_RD;
        else if (kind_r == ffha_pkg::KIND_REALLOC && size_r != 32'd0 &&
                 rd_size_r < size_r) st_nxt = ffha_pkg::S_FIT_RD;
        else st_nxt = ffha_pkg::S_OUT;
      end
      ffha_pkg::S_FIT_RD:
        st_nxt = (idx_r >= count_r) ? ffha_pkg::S_APPEND : ffha_pkg::S_FIT_CMP;
      ffha_pkg::S_FIT_CMP:
        st_nxt = (rd_free_r && {3'd0, rd_size_r} >= need_r) ?
                 ffha_pkg::S_FINISH : ffha_pkg::S_FIT_RD;
      ffha_pkg::S_APPEND: st_nxt = ffha_pkg::S_FINISH;
      ffha_pkg::S_FINISH: st_nxt = ffha_pkg::S_OUT;
      ffha_pkg::S_OUT: if (out_ready) st_nxt = ffha_pkg::S_IDLE;
      default: st_nxt = ffha_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ffha_pkg::S_IDLE;
      heap_start_r <= 48'd0;
      heap_cap_r <= 32'd1048576;
      count_r <= '0;
      used_r <= 33'd0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid) begin
        if (cfg_index == ffha_pkg::REG_HEAP_START) heap_start_r <= cfg_data;
        else heap_cap_r <= cfg_data[31:0];
      end
      if (st_r == ffha_pkg::S_APPEND && stat_r == ffha_pkg::ST_OK &&
          total <= {4'd0, heap_cap_r} && count_r < CW'(MAX_BLOCKS) &&
          need_r <= 35'hFFFFFFFF) begin
        count_r <= count_r + CW'(1);
        used_r <= total[32:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= mem_addr[idx_r[IW-1:0]];
    rd_size_r <= mem_size[idx_r[IW-1:0]];
    rd_free_r <= mem_free[idx_r[IW-1:0]];
    case (st_r)
      ffha_pkg::S_IDLE: if (in_valid) begin
        kind_r <= in_kind;
        size_r <= in_request_size;
        baddr_r <= in_block_address;
        align_r <= in_alignment;
        res_r <= 48'd0; raw_r <= 48'd0; copy_r <= 32'd0;
        stat_r <= ffha_pkg::ST_OK;
        moving_r <= 1'b0;
        idx_r <= '0;
      end
      ffha_pkg::S_DECODE: begin
        need_r <= need_calc;
        if (kind_r == ffha_pkg::KIND_ALIGNED &&
            (align_r < 17'd8 || (align_r & am1) != 17'd0))
          stat_r <= ffha_pkg::ST_INVALID;
      end
      ffha_pkg::S_FIND_RD: if (idx_r >= count_r) stat_r <= ffha_pkg::ST_UNKNOWN;
      ffha_pkg::S_FIND_CMP: begin
        if (rd_addr_r != baddr_r) idx_r <= idx_r + CW'(1);
        else if (kind_r == ffha_pkg::KIND_REALLOC && size_r != 32'd0) begin
          if (rd_size_r < size_r) begin
            moving_r <= 1'b1;
            old_idx_r <= idx_r[IW-1:0];
            old_size_r <= rd_size_r;
            idx_r <= '0;
          end else res_r <= baddr_r;
        end else mem_free[idx_r[IW-1:0]] <= 1'b1;
      end
      ffha_pkg::S_FIT_CMP: begin
        if (rd_free_r && {3'd0, rd_size_r} >= need_r) begin
          mem_free[idx_r[IW-1:0]] <= 1'b0;
          res_r <= rd_addr_r;
        end else idx_r <= idx_r + CW'(1);
      end
      ffha_pkg::S_APPEND: begin
        if (total <= {4'd0, heap_cap_r} && count_r < CW'(MAX_BLOCKS) &&
            need_r <= 35'hFFFFFFFF) begin
          res_r <= heap_start_r + {15'd0, used_r} + 48'(HEADER_BYTES);
          mem_addr[idx_r[IW-1:0]] <= heap_start_r + {15'd0, used_r} +
                                     48'(HEADER_BYTES);
          mem_size[idx_r[IW-1:0]] <= need_r[31:0];
          mem_free[idx_r[IW-1:0]] <= 1'b0;
        end else stat_r <= ffha_pkg::ST_NOMEM;
      end
      ffha_pkg::S_FINISH: begin
        if (stat_r == ffha_pkg::ST_OK) begin
          if (moving_r) begin
            mem_free[old_idx_r] <= 1'b1;
            copy_r <= old_size_r;
          end
          if (kind_r == ffha_pkg::KIND_ALIGNED) begin
            raw_r <= res_r;
            res_r <= aligned;
          end
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* sim/ffha_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffha_checker: result predictor and scoreboard for the heap allocator
// Watches the cfg, in and out channels, tracks the block table, the heap
// usage and the register values, and compares every result item field by
// field with the oldest expected one.
// ----------------------------------------------------------------------------
module ffha_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_request_size,
  input  logic [47:0] in_block_address,
  input  logic [16:0] in_alignment,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [47:0] out_result_address,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_copy_length,
  input  logic [47:0] out_raw_address,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output int          errors,
  output int          pending
);
  localparam int TABLE_DEPTH = 64;
  localparam longint unsigned HDR = 32;
  localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [47:0]       result_address;
    ffha_pkg::status_t status;
    logic [31:0]       copy_length;
    logic [47:0]       raw_address;
  } alloc_result_t;

  logic [47:0]     blk_addr [TABLE_DEPTH];
  longint unsigned blk_size [TABLE_DEPTH];
  bit              blk_free [TABLE_DEPTH];
  int              blk_count;
  longint unsigned heap_used;
  logic [47:0]     heap_base;
  logic [31:0]     heap_cap;
  alloc_result_t   expected_q[$];

  task automatic alloc_block(input longint unsigned sz, output ffha_pkg::status_t st,
                             output logic [47:0] addr);
    longint unsigned need;
    bit found;
    found = 0;
    addr = '0;
    st = ffha_pkg::ST_OK;
    if (sz != 0) begin
      need = (sz + 7) & ~64'd7;
      for (int i = 0; i < blk_count; i++) begin
        if (!found && blk_free[i] && blk_size[i] >= need) begin
          blk_free[i] = 0;
          addr = blk_addr[i];
          found = 1;
        end
      end
      if (!found) begin
        if (blk_count >= TABLE_DEPTH || need > 64'hFFFF_FFFF ||
            heap_used + need + HDR > {32'd0, heap_cap}) begin
          st = ffha_pkg::ST_NOMEM;
        end else begin
          blk_addr[blk_count] = 48'(({16'd0, heap_base} + heap_used + HDR) & MASK48);
          blk_size[blk_count] = need;
          blk_free[blk_count] = 0;
          addr = blk_addr[blk_count];
          blk_count++;
          heap_used += need + HDR;
        end
      end
    end
  endtask

  function automatic int find_block(logic [47:0] addr);
    for (int i = 0; i < blk_count; i++)
      if (blk_addr[i] == addr) return i;
    return -1;
  endfunction

  task automatic free_block(input logic [47:0] addr, output ffha_pkg::status_t st);
    int e;
    st = ffha_pkg::ST_OK;
    if (addr != 0) begin
      e = find_block(addr);
      if (e < 0) st = ffha_pkg::ST_UNKNOWN;
      else blk_free[e] = 1;
    end
  endtask

  task automatic predict_request(output alloc_result_t r);
    int e;
    longint unsigned al;
    longint unsigned sz;
    longint unsigned old_size;
    logic [47:0] a;
    r.result_address = '0;
    r.status = ffha_pkg::ST_OK;
    r.copy_length = '0;
    r.raw_address = '0;
    al = {47'd0, in_alignment};
    sz = {32'd0, in_request_size};
    case (ffha_pkg::kind_t'(in_kind))
      ffha_pkg::KIND_ALLOC: alloc_block(sz, r.status, r.result_address);
      ffha_pkg::KIND_FREE: free_block(in_block_address, r.status);
      ffha_pkg::KIND_REALLOC: begin
        if (in_block_address == 0) begin
          alloc_block(sz, r.status, r.result_address);
        end else if (in_request_size == 0) begin
          free_block(in_block_address, r.status);
        end else begin
          e = find_block(in_block_address);
          if (e < 0) begin
            r.status = ffha_pkg::ST_UNKNOWN;
          end else if (blk_size[e] >= sz) begin
            r.result_address = in_block_address;
          end else begin
            old_size = blk_size[e];
            alloc_block(sz, r.status, r.result_address);
            if (r.status == ffha_pkg::ST_OK) begin
              blk_free[e] = 1;
              r.copy_length = old_size[31:0];
            end
          end
        end
      end
      default: begin
        if (al < 8 || (al & (al - 1)) != 0) begin
          r.status = ffha_pkg::ST_INVALID;
        end else if (in_request_size != 0) begin
          alloc_block(sz + al - 1 + 8, r.status, a);
          if (r.status == ffha_pkg::ST_OK) begin
            r.raw_address = a;
            r.result_address = 48'((({16'd0, a} + 64'd8 + al - 1) & ~(al - 1)) & MASK48);
          end
        end
      end
    endcase
  endtask

  task automatic compare_result();
    alloc_result_t x;
    if (expected_q.size() == 0) begin
      $error("result item with no expectation waiting");
      errors++;
    end else begin
      x = expected_q.pop_front();
      if (out_result_address !== x.result_address) begin
        $error("result_address expected %h actual %h", x.result_address,
               out_result_address);
        errors++;
      end
      if (out_status !== x.status) begin
        $error("status expected %0d actual %0d", x.status, out_status);
        errors++;
      end
      if (out_copy_length !== x.copy_length) begin
        $error("copy_length expected %h actual %h", x.copy_length, out_copy_length);
        errors++;
      end
      if (out_raw_address !== x.raw_address) begin
        $error("raw_address expected %h actual %h", x.raw_address, out_raw_address);
        errors++;
      end
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    alloc_result_t r;
    if (!rst_n) begin
      blk_count = 0;
      heap_used = 0;
      heap_base = '0;
      heap_cap = 32'd1048576;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ffha_pkg::REG_HEAP_START) heap_base = cfg_data;
        else heap_cap = cfg_data[31:0];
      end
      if (out_valid && out_ready) compare_result();
      if (in_valid && in_ready) begin
        predict_request(r);
        expected_q.push_back(r);
      end
    end
    pending = expected_q.size();
  end
endmodule

/* sim/tb_first_fit_heap_allocator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator: testbench for the first-fit heap allocator
// Drives directed and random allocate, free, reallocate and aligned requests
// over several heap base and capacity settings, with random idling on both
// channels; results are checked by ffha_checker.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [31:0] in_request_size = '0;
  logic [47:0] in_block_address = '0;
  logic [16:0] in_alignment = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [47:0] out_result_address;
  logic [1:0]  out_status;
  logic [31:0] out_copy_length;
  logic [47:0] out_raw_address;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;
  int          errors;
  int          pending;

  bit          idle_on = 1;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  int          status_count [4];
  int          item_count = 0;
  logic [47:0] addr_pool[$];
  logic [47:0] last_addr = '0;

  always #5 clk = ~clk;

  first_fit_heap_allocator DUT (.*);

  ffha_checker u_checker (.*);

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      status_count[out_status]++;
      if (out_status == ffha_pkg::ST_OK && out_result_address != 0) begin
        last_addr = out_result_address;
        addr_pool.push_back(out_result_address);
        if (out_raw_address != 0) addr_pool.push_back(out_raw_address);
        while (addr_pool.size() > 32) void'(addr_pool.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_first_fit_heap_allocator NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(ffha_pkg::kind_t k, logic [31:0] sz, logic [47:0] addr,
                              logic [16:0] al);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    in_kind <= k;
    in_request_size <= sz;
    in_block_address <= addr;
    in_alignment <= al;
    item_count++;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [47:0] val);
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 0;
  endtask

  function automatic logic [47:0] pick_address();
    int r;
    r = $urandom_range(0, 99);
    if (addr_pool.size() != 0 && r < 60)
      return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    if (addr_pool.size() != 0 && r < 70)
      return addr_pool[$urandom_range(0, addr_pool.size() - 1)] + 48'd8;
    if (r < 80) return '0;
    return 48'({$urandom, $urandom});
  endfunction

  task automatic random_request();
    int r;
    ffha_pkg::kind_t k;
    logic [31:0] sz;
    logic [16:0] al;
    r = $urandom_range(0, 99);
    k = r < 35 ? ffha_pkg::KIND_ALLOC : r < 60 ? ffha_pkg::KIND_FREE :
        r < 85 ? ffha_pkg::KIND_REALLOC : ffha_pkg::KIND_ALIGNED;
    r = $urandom_range(0, 99);
    sz = r < 70 ? $urandom_range(1, 256) : r < 80 ? 32'd0 :
         r < 90 ? $urandom_range(0, 8192) : $urandom;
    if ($urandom_range(0, 3) != 0) al = 17'd1 << $urandom_range(3, 16);
    else al = 17'($urandom_range(0, 131071));
    send_request(k, sz, pick_address(), al);
  endtask

  initial begin
    logic [47:0] a;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    write_reg(ffha_pkg::REG_HEAP_START, 48'h0000_0001_0000);
    write_reg(ffha_pkg::REG_HEAP_CAP, 48'd1048576);

    send_request(ffha_pkg::KIND_ALLOC, 32'd0, '0, '0);
    send_request(ffha_pkg::KIND_ALLOC, 32'd1, '0, '0);
    send_request(ffha_pkg::KIND_ALLOC, 32'd8, '0, '0);
    send_request(ffha_pkg::KIND_ALLOC, 32'hFFFF_FFFF, '0, '0);
    send_request(ffha_pkg::KIND_ALLOC, 32'd9, '0, '0);
    drain();
    a = last_addr;
    send_request(ffha_pkg::KIND_FREE, '0, '0, '0);
    send_request(ffha_pkg::KIND_FREE, '0, a, '0);
    send_request(ffha_pkg::KIND_FREE, '0, a, '0);
    send_request(ffha_pkg::KIND_FREE, '0, 48'h123, '0);
    send_request(ffha_pkg::KIND_ALLOC, 32'd16, '0, '0);
    send_request(ffha_pkg::KIND_REALLOC, 32'd24, '0, '0);
    drain();
    a = last_addr;
    send_request(ffha_pkg::KIND_REALLOC, 32'd20, a, '0);
    send_request(ffha_pkg::KIND_REALLOC, 32'd200, a, '0);
    send_request(ffha_pkg::KIND_REALLOC, 32'd40, 48'hFFFF_FFFF_FFFF, '0);
    drain();
    send_request(ffha_pkg::KIND_REALLOC, 32'd0, last_addr, '0);
    send_request(ffha_pkg::KIND_REALLOC, 32'hFFFF_FFFF, a, '0);
    send_request(ffha_pkg::KIND_ALIGNED, 32'd8, '0, 17'd4);
    send_request(ffha_pkg::KIND_ALIGNED, 32'd8, '0, 17'd24);
    send_request(ffha_pkg::KIND_ALIGNED, 32'd8, '0, 17'd0);
    send_request(ffha_pkg::KIND_ALIGNED, 32'd8, '0, 17'h1FFFF);
    send_request(ffha_pkg::KIND_ALIGNED, 32'd0, '0, 17'd16);
    send_request(ffha_pkg::KIND_ALIGNED, 32'd33, '0, 17'd8);
    send_request(ffha_pkg::KIND_ALIGNED, 32'd100, '0, 17'd65536);

    repeat (300) random_request();
    write_reg(ffha_pkg::REG_HEAP_START, 48'hFFFF_FFFF_F000);
    write_reg(ffha_pkg::REG_HEAP_CAP, 48'd4096);
    repeat (200) random_request();
    write_reg(ffha_pkg::REG_HEAP_CAP, 48'd0);
    repeat (100) random_request();
    write_reg(ffha_pkg::REG_HEAP_START, 48'd0);
    write_reg(ffha_pkg::REG_HEAP_CAP, 48'hFFFF_FFFF);
    repeat (250) random_request();
    write_reg(ffha_pkg::REG_HEAP_START, 48'({$urandom, $urandom}) & 48'hFFFF_FFFF_F000);
    idle_on = 0;
    repeat (250) random_request();

    drain();
    repeat (50) @(posedge clk);
    $display("%0d requests over five register settings: ok %0d, out of memory %0d,",
             item_count, status_count[ffha_pkg::ST_OK], status_count[ffha_pkg::ST_NOMEM]);
    $display("invalid argument %0d, unknown address %0d",
             status_count[ffha_pkg::ST_INVALID], status_count[ffha_pkg::ST_UNKNOWN]);
    if (errors == 0 && pending == 0) begin
      $display("tb_first_fit_heap_allocator OK");
    end else begin
      $display("tb_first_fit_heap_allocator NOT OK");
    end
    $finish;
  end
endmodule

/* first_fit_heap_allocator.f */
hw/rtl/ffha_pkg.sv
hw/rtl/first_fit_heap_allocator.sv
sim/ffha_checker.sv
sim/tb_first_fit_heap_allocator.sv
